/* rtl/mexp_pkg.sv */
// Shared constants for the modular exponentiation block.
package mexp_pkg;

    // Operand and exponent word width
    localparam int OPND_W = 32;
    // Bit counter for one serial multiplication (counts OPND_W down to 0)
    localparam int CNT_W = $clog2(OPND_W + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'd1;

    // Register reset values
    localparam logic [OPND_W-1:0] RESET_MODULUS  = 32'd1529059723;
    localparam logic [OPND_W-1:0] RESET_EXPONENT = 32'd65557;

endpackage

/* rtl/mexp_modmul.sv */
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
module mexp_modmul #(
    parameter int MOD_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [MOD_BITS-1:0]           op_a,
    input  logic [mexp_pkg::OPND_W-1:0]   op_b,
    input  logic [MOD_BITS-1:0]           modulus,
    output logic                          done,
    output logic [MOD_BITS-1:0]           result
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [mexp_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MOD_BITS-1:0]           a_reg, a_next;
    logic [mexp_pkg::OPND_W-1:0]   b_reg, b_next;
    logic [MOD_BITS-1:0]           r_reg, r_next;

    logic [MOD_BITS:0]             dbl;
    logic [MOD_BITS-1:0]           dbl_red;
    logic [MOD_BITS:0]             sum;
    logic [MOD_BITS-1:0]           sum_red;

    // One step: r = (2r + a*bit) mod m, with r < m and a <= m
    always_comb
    begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, modulus}) ? MOD_BITS'(dbl - {1'b0, modulus})
                                           : MOD_BITS'(dbl);
        sum     = {1'b0, dbl_red} + (b_reg[mexp_pkg::OPND_W-1] ? {1'b0, a_reg}
                                                                : '0);
        sum_red = (sum >= {1'b0, modulus}) ? MOD_BITS'(sum - {1'b0, modulus})
                                           : MOD_BITS'(sum);
    end

    // Sequencing of the serial steps
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = mexp_pkg::CNT_W'(mexp_pkg::OPND_W);
            a_next    = op_a;
            b_next    = op_b;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next   = sum_red;
            b_next   = {b_reg[mexp_pkg::OPND_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mexp_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

/* rtl/modular_exponentiation.sv */
// Top level: right-to-left square-and-multiply modular exponentiation.
//
// Each transaction on the input channel yields one power_result =
// base_value ^ exponent mod modulus. An item takes one reduction of the base
// plus one modular multiplication per exponent bit that is set and one
// squaring per exponent bit below the highest set bit; every multiplication
// runs through a bit-serial unit that handles one operand bit per cycle,
// with sequencing states around each. A 32-bit exponent of all ones thus
// costs 64 multiplications; the default exponent 65557 costs about 20.
// A zero exponent returns 1 and a zero modulus returns 0. One item is worked
// on at a time; the finished result sits in an output register, so the next
// item is accepted while it waits to be taken.
// Configuration writes are to be made only while the block is idle.
module modular_exponentiation #(
    parameter int MOD_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [31:0]                      base_value,
    // Output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [31:0]                      power_result,
    // Configuration write port
    input  logic                             cfg_write,
    input  logic [mexp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_ACC,
        ST_SQ,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    logic [MOD_BITS-1:0]             modulus_reg;
    logic [mexp_pkg::OPND_W-1:0]     exponent_reg;
    logic [mexp_pkg::OPND_W-1:0]     exp_reg;
    logic [MOD_BITS-1:0]             acc_reg;
    logic [MOD_BITS-1:0]             sq_reg;
    logic [MOD_BITS-1:0]             res_reg;
    logic                            mm_start_reg;
    logic [MOD_BITS-1:0]             op_a_reg;
    logic [mexp_pkg::OPND_W-1:0]     op_b_reg;
    logic                            out_valid_reg;
    logic [31:0]                     power_result_reg;

    logic                            mm_done;
    logic [MOD_BITS-1:0]             mm_result;
    logic [mexp_pkg::OPND_W-1:0]     exp_shift;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= mexp_pkg::RESET_MODULUS[MOD_BITS-1:0];
            exponent_reg <= mexp_pkg::RESET_EXPONENT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mexp_pkg::REG_MODULUS:  modulus_reg  <= cfg_data[MOD_BITS-1:0];
                mexp_pkg::REG_EXPONENT: exponent_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Serial modular multiplier shared by all steps
    mexp_modmul #(
        .MOD_BITS (MOD_BITS)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start_reg),
        .op_a    (op_a_reg),
        .op_b    (op_b_reg),
        .modulus (modulus_reg),
        .done    (mm_done),
        .result  (mm_result)
    );

    assign exp_shift = exp_reg >> 1;

    // Sequencer: state, operands and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mm_start_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            exp_reg          <= '0;
            acc_reg          <= '0;
            sq_reg           <= '0;
            res_reg          <= '0;
            op_a_reg         <= '0;
            op_b_reg         <= '0;
            power_result_reg <= '0;
        end
        else
        begin
            // Multiplier start: base reduction, every step, square after a multiply
            mm_start_reg <= ((state_reg == ST_IDLE) && in_valid &&
                             (exponent_reg != '0) && (modulus_reg != '0)) ||
                            (state_reg == ST_STEP) ||
                            ((state_reg == ST_ACC) && mm_done && (exp_shift != '0));

            // Output register is loaded from ST_DONE, held while stalled
            out_valid_reg <= (state_reg == ST_DONE) || (out_valid_reg && out_stall);

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        priority if (exponent_reg == '0)
                        begin
                            res_reg   <= MOD_BITS'(1);
                            state_reg <= ST_DONE;
                        end
                        else if (modulus_reg == '0)
                        begin
                            res_reg   <= '0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            // Base reduction as 1 * base mod m
                            exp_reg      <= exponent_reg;
                            op_a_reg     <= MOD_BITS'(1);
                            op_b_reg     <= base_value;
                            state_reg    <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE:
                begin
                    if (mm_done)
                    begin
                        sq_reg    <= mm_result;
                        acc_reg   <= MOD_BITS'(1);
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP:
                begin
                    priority if (exp_reg[0])
                    begin
                        op_a_reg     <= acc_reg;
                        op_b_reg     <= mexp_pkg::OPND_W'(sq_reg);
                        state_reg    <= ST_ACC;
                    end
                    else
                    begin
                        // Bit clear; exponent is nonzero so a square follows
                        exp_reg      <= exp_shift;
                        op_a_reg     <= sq_reg;
                        op_b_reg     <= mexp_pkg::OPND_W'(sq_reg);
                        state_reg    <= ST_SQ;
                    end
                end
                ST_ACC:
                begin
                    if (mm_done)
                    begin
                        exp_reg <= exp_shift;
                        priority if (exp_shift == '0)
                        begin
                            res_reg   <= mm_result;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            acc_reg      <= mm_result;
                            op_a_reg     <= sq_reg;
                            op_b_reg     <= mexp_pkg::OPND_W'(sq_reg);
                            state_reg    <= ST_SQ;
                        end
                    end
                end
                ST_SQ:
                begin
                    if (mm_done)
                    begin
                        sq_reg    <= mm_result;
                        state_reg <= ST_STEP;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        power_result_reg <= 32'(res_reg);
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign power_result = power_result_reg;

endmodule

/* tb/sv/modular_exponentiation_tb.sv */
// Testbench for modular_exponentiation: directed key cases, then random keys and bases.
`timescale 1ns / 100ps

module modular_exponentiation_tb;

    localparam int          MOD_BITS       = 32;
    localparam logic [31:0] MOD_MASK       = 32'hFFFF_FFFF >> (32 - MOD_BITS);
    localparam logic [31:0] RST_MOD        = mexp_pkg::RESET_MODULUS;
    localparam logic [31:0] RST_EXP        = mexp_pkg::RESET_EXPONENT;
    localparam int          NUM_DIRECTED   = 22;
    localparam int          NUM_PHASES     = 12;
    localparam int          PHASE_ITEMS    = 26;
    localparam int          SLOW_ITEMS     = 5;
    localparam int          PRESSURE_PHASE = 5;
    localparam int          PRESSURE_HOLD  = 2000;
    localparam int          DRAIN_CYCLES   = 64;
    localparam int          REPORT_LIMIT   = 10;

    // One directed row: key, base and, where obvious, the typed-in result
    typedef struct packed {
        logic [31:0] modulus;
        logic [31:0] exponent;
        logic [31:0] base;
        logic        typed;
        logic [31:0] power;
    } key_case_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [31:0]                    base_value;
    logic                           out_valid;
    logic                           out_stall;
    logic [31:0]                    power_result;
    logic                           cfg_write;
    logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                    cfg_data;

    // Key currently loaded in the block, as the predictor sees it
    logic [31:0] key_modulus = RST_MOD & MOD_MASK;
    logic [31:0] key_exponent = RST_EXP;

    logic [31:0] pending_powers[$];
    int          bases_sent = 0;
    int          results_checked = 0;
    int          key_loads = 0;
    int          fail_count = 0;
    bit          tx_idle = 1'b0;
    bit          rx_idle = 1'b0;
    bit          hold_request = 1'b0;

    key_case_t key_cases [0:NUM_DIRECTED-1] = '{
        '{RST_MOD,       RST_EXP,        32'd0,          1'b1, 32'd0},
        '{RST_MOD,       RST_EXP,        32'd1,          1'b1, 32'd1},
        '{RST_MOD,       RST_EXP,        32'd12345,      1'b0, 32'd0},
        '{RST_MOD,       RST_EXP,        32'hFFFF_FFFF,  1'b0, 32'd0},
        '{32'hFFFF_FFFF, 32'd1,          32'hFFFF_FFFE,  1'b1, 32'hFFFF_FFFE},
        '{32'hFFFF_FFFF, 32'd1,          32'hFFFF_FFFF,  1'b1, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF,  32'd2,          1'b0, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b0, 32'd0},
        '{32'hFFFF_FFFF, 32'd0,          32'd123,        1'b1, 32'd1},
        '{32'd1,         32'd0,          32'hFFFF_FFFF,  1'b1, 32'd1},
        '{32'd1,         32'd7,          32'hFFFF_FFFF,  1'b1, 32'd0},
        '{32'd1,         32'hFFFF_FFFF,  32'd5,          1'b1, 32'd0},
        '{32'd0,         32'd0,          32'd9,          1'b1, 32'd1},
        '{32'd0,         32'd5,          32'd9,          1'b1, 32'd0},
        '{32'd0,         32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd0},
        '{32'd97,        32'd2,          32'd1000,       1'b0, 32'd0},
        '{32'd2,         32'd3,          32'hFFFF_FFFF,  1'b0, 32'd0},
        '{32'd3233,      32'd17,         32'd65,         1'b1, 32'd2790},
        '{32'd3233,      32'd2753,       32'd2790,       1'b1, 32'd65},
        '{32'h8000_0000, 32'd2,          32'h7FFF_FFFF,  1'b0, 32'd0},
        '{32'hFFFF_FFFB, 32'hFFFF_FFFA,  32'd3,          1'b1, 32'd1},
        '{32'hFFFF_FFFB, 32'hFFFF_FFFA,  32'hFFFF_FFFF,  1'b0, 32'd0}
    };

    modular_exponentiation #(
        .MOD_BITS(MOD_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .base_value(base_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .power_result(power_result),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Right-to-left square-and-multiply over 64-bit intermediates
    function automatic logic [31:0] predict_power(input logic [31:0] base,
                                                  input logic [31:0] expo,
                                                  input logic [31:0] modulus);
        logic [63:0] acc;
        logic [63:0] square;
        logic [31:0] bits_left;
        if (expo == 32'd0)
            return 32'd1;
        if (modulus == 32'd0)
            return 32'd0;
        acc = 64'd1;
        square = {32'd0, base} % {32'd0, modulus};
        bits_left = expo;
        while (bits_left != 32'd0)
        begin
            if (bits_left[0])
                acc = (acc * square) % {32'd0, modulus};
            bits_left = bits_left >> 1;
            square = (square * square) % {32'd0, modulus};
        end
        return acc[31:0];
    endfunction

    function automatic int draw_wait(input bit enabled);
        return enabled ? int'($urandom_range(0, 13)) : 0;
    endfunction

    // Mix of full-range bases, reduced bases and edge values
    function automatic logic [31:0] pick_base(input logic [31:0] modulus);
        case ($urandom_range(0, 5))
            1: return (modulus > 32'd1) ? 32'($urandom_range(modulus - 1, 0)) : $urandom;
            2: return modulus - 32'd1;
            3: return 32'($urandom_range(0, 3));
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Nonzero exponent with its top set bit at position width-1
    function automatic logic [31:0] pick_exponent(input int width);
        logic [31:0] expo;
        expo = $urandom >> (32 - width);
        expo[width-1] = 1'b1;
        return expo;
    endfunction

    // Offer one base and record its expected power once accepted
    task automatic send_base(input logic [31:0] base, input logic typed,
                             input logic [31:0] power);
        in_valid <= 1'b1;
        base_value <= base;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_powers.push_back(typed ? power : predict_power(base, key_exponent, key_modulus));
        bases_sent++;
    endtask

    task automatic pause_input(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Key registers are loaded only once every result has been taken
    task automatic load_key(input logic [31:0] modulus, input logic [31:0] expo);
        in_valid <= 1'b0;
        while (pending_powers.size() != 0)
            @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= mexp_pkg::REG_MODULUS;
        cfg_data <= modulus;
        @(posedge clk);
        cfg_index <= mexp_pkg::REG_EXPONENT;
        cfg_data <= expo;
        @(posedge clk);
        cfg_write <= 1'b0;
        key_modulus = modulus & MOD_MASK;
        key_exponent = expo;
        key_loads++;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stimulus: reset, directed key cases, then random key phases
    initial
    begin : stimulus
        int          kind;
        int          count;
        int          gap;
        logic [31:0] modulus;
        logic [31:0] expo;

        rst_n = 1'b0;
        in_valid = 1'b0;
        base_value = 32'd0;
        cfg_write = 1'b0;
        cfg_index = mexp_pkg::REG_MODULUS;
        cfg_data = 32'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with random gaps on both sides
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        foreach (key_cases[i])
        begin
            if (key_cases[i].modulus != key_modulus || key_cases[i].exponent != key_exponent)
                load_key(key_cases[i].modulus, key_cases[i].exponent);
            send_base(key_cases[i].base, key_cases[i].typed, key_cases[i].power);
            gap = draw_wait(tx_idle);
            if (gap > 0)
                pause_input(gap);
        end

        // Random phases; one key per phase
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            kind = p % 6;
            count = PHASE_ITEMS;
            case (kind)
                0:
                begin
                    modulus = $urandom;
                    expo = pick_exponent($urandom_range(1, 12));
                end
                1:
                begin
                    modulus = 32'($urandom_range(2, 255));
                    expo = pick_exponent($urandom_range(1, 16));
                end
                2:
                begin
                    // Full-width exponent: slow, so only a few bases
                    modulus = $urandom;
                    expo = (p < 6) ? pick_exponent(32) : 32'hFFFF_FFFF;
                    count = SLOW_ITEMS;
                end
                3:
                begin
                    modulus = 32'($urandom_range(0, 3));
                    expo = pick_exponent($urandom_range(1, 10));
                end
                4:
                begin
                    modulus = $urandom;
                    expo = 32'd0;
                end
                default:
                begin
                    modulus = $urandom;
                    expo = pick_exponent($urandom_range(1, 8));
                end
            endcase
            load_key(modulus, expo);

            if (p == 0)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            else if (p == PRESSURE_PHASE)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b1;
                hold_request = 1'b1;
            end
            else
            begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end

            for (int n = 0; n < count; n++)
            begin
                send_base(pick_base(key_modulus), 1'b0, 32'd0);
                gap = draw_wait(tx_idle);
                if (gap > 0)
                    pause_input(gap);
            end
        end

        // Drain, then give the block time to show any stray result
        pause_input(0);
        while (pending_powers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d bases (%0d directed) over %0d key loads, incl. zero exponent,",
                 bases_sent, NUM_DIRECTED, key_loads);
        $display("modulus 0/1, full-width keys, a %0d-cycle hold-off; %0d results checked.",
                 PRESSURE_HOLD, results_checked);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side: random stall per transaction, one long hold-off on request
    initial
    begin : result_side
        int          hold;
        logic [31:0] want;

        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            hold = 0;
            if (out_valid && !out_stall)
            begin
                if (pending_powers.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected power_result %h", $time, power_result);
                end
                else
                begin
                    want = pending_powers.pop_front();
                    results_checked++;
                    if (power_result !== want)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: power_result mismatch: expected %h, got %h",
                                     $time, want, power_result);
                    end
                end
                hold = draw_wait(rx_idle);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold = PRESSURE_HOLD;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    initial
    begin
        #50_000_000;
        $display("Timed out with %0d results outstanding", pending_powers.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
rtl/mexp_pkg.sv
rtl/mexp_modmul.sv
rtl/modular_exponentiation.sv
tb/sv/modular_exponentiation_tb.sv
